// File: hdl/clb_pkg.sv
// Shared types and constants for the compacting list buffer.
// Beat payloads, request and status codes, and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package clb_pkg;

  // Store geometry
  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Request kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request beat
  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
    logic        [7:0]  position;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] read_value;
    logic        [8:0]  fill_count;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // request beat accepted this cycle
    logic shift_en;  // walk the entries after the deleted position
    logic commit;    // update the store and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_shift;    // incoming request is a delete inside the fill count
    logic shift_done;  // every later entry has been moved down
    logic out_free;    // result register can take a new beat
  } sts_t;

endpackage

// File: hdl/compacting_list_buffer_unit.sv
// Top level of the compacting list buffer: controller plus datapath.
// Depends on clb_pkg, clb_ctrl and clb_datapath.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | clb_pkg::in_t  (kind, value, position)
//   out_    | output    | out_valid/out_stall | clb_pkg::out_t (status, read_value, fill_count)
//
// Append, read, no-op and refused requests go from the accept straight to the
// finish state; the input stalls until the controller returns to idle.
// A delete moves n = fill_count - position - 1 entries, one per cycle through
// the memory, in the shift state between accept and finish.
// Reset empties the store at once; entry contents are left as they are.
// A stalled result holds the block in its last phase; the next beat is taken
// once the result register frees.
`timescale 1ns / 1ps

module compacting_list_buffer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output clb_pkg::out_t out_data
);

  clb_pkg::cmd_t cmd;
  clb_pkg::sts_t sts;

  clb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hdl/clb_datapath.sv
// Datapath of the compacting list buffer: entry memory, fill count,
// request holding register, shift walker and result register.
// Depends on clb_pkg.
`timescale 1ns / 1ps

module clb_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  clb_pkg::in_t   in_data,
  input  clb_pkg::cmd_t  cmd,
  output clb_pkg::sts_t  sts,
  output logic           out_valid,
  input  logic           out_stall,
  output clb_pkg::out_t  out_data
);

  // Entry memory, undefined until written
  logic signed [31:0] mem [clb_pkg::CAPACITY];

  logic [clb_pkg::CNT_W-1:0]  count_r, count_nxt;
  clb_pkg::in_t               req_r;
  logic [1:0]                 st_r, st_in;
  logic signed [31:0]         rd_data_r;
  logic [clb_pkg::CNT_W-1:0]  ridx_r;
  logic [clb_pkg::ADDR_W-1:0] waddr_r;
  logic                       pend_r;
  logic                       out_valid_r;
  clb_pkg::out_t              out_data_r;

  logic                       pos_ok;
  logic                       issue;
  logic                       rd_en;
  logic [clb_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;
  logic [clb_pkg::ADDR_W-1:0] wr_addr;
  logic signed [31:0]         wr_data;
  logic                       app_ok;
  logic                       del_ok;
  logic [clb_pkg::CNT_W-1:0]  pos_ext;

  // Classify the incoming request against the current fill count
  assign pos_ext = clb_pkg::CNT_W'(in_data.position);
  assign pos_ok  = pos_ext < count_r;

  always_comb begin
    st_in = clb_pkg::ST_OK;
    unique case (in_data.kind)
      clb_pkg::KIND_APPEND: begin
        if (count_r == clb_pkg::CNT_W'(clb_pkg::CAPACITY)) st_in = clb_pkg::ST_FULL;
      end
      clb_pkg::KIND_DELETE,
      clb_pkg::KIND_READ: begin
        if (!pos_ok) st_in = clb_pkg::ST_RANGE;
      end
      default: st_in = clb_pkg::ST_OK;
    endcase
  end

  // Shift walker: read entry ridx, write it one place lower in the next cycle
  assign issue = cmd.shift_en && (ridx_r < count_r);

  // Memory port selection
  assign rd_en   = issue || (cmd.load && in_data.kind == clb_pkg::KIND_READ);
  assign rd_addr = issue ? ridx_r[clb_pkg::ADDR_W-1:0] : in_data.position;

  assign app_ok  = (req_r.kind == clb_pkg::KIND_APPEND) && (st_r == clb_pkg::ST_OK);
  assign del_ok  = (req_r.kind == clb_pkg::KIND_DELETE) && (st_r == clb_pkg::ST_OK);

  assign wr_en   = pend_r || (cmd.commit && app_ok);
  assign wr_addr = pend_r ? waddr_r : count_r[clb_pkg::ADDR_W-1:0];
  assign wr_data = pend_r ? rd_data_r : req_r.value;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Fill count after the commit
  always_comb begin
    count_nxt = count_r;
    if (app_ok)      count_nxt = count_r + clb_pkg::CNT_W'(1);
    else if (del_ok) count_nxt = count_r - clb_pkg::CNT_W'(1);
  end

  // Hold the request and walk state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data;
      st_r   <= st_in;
      ridx_r <= pos_ext + clb_pkg::CNT_W'(1);
    end else if (issue) begin
      ridx_r <= ridx_r + clb_pkg::CNT_W'(1);
    end
    if (issue) begin
      waddr_r <= clb_pkg::ADDR_W'(ridx_r - clb_pkg::CNT_W'(1));
    end
  end

  // Control registers: fill count, pending write, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.status     <= st_r;
      out_data_r.read_value <= (req_r.kind == clb_pkg::KIND_READ && st_r == clb_pkg::ST_OK)
                               ? rd_data_r : 32'sd0;
      out_data_r.fill_count <= 9'(count_nxt);
    end
  end

  assign sts.is_shift   = (in_data.kind == clb_pkg::KIND_DELETE) && pos_ok;
  assign sts.shift_done = !(ridx_r < count_r) && !pend_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/clb_ctrl.sv
// Controller of the compacting list buffer: sequences accept, shift and
// commit of one request at a time.
// Depends on clb_pkg.
`timescale 1ns / 1ps

module clb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clb_pkg::sts_t sts,
  output clb_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Commands follow the current state
  assign cmd.load     = accept;
  assign cmd.shift_en = (state_r == S_SHIFT);
  assign cmd.commit   = (state_r == S_FINISH) && sts.out_free;

  // Advance the request through its phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) state_r <= sts.is_shift ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          if (sts.shift_done) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/clb_checker.sv
// Port-level checks for the compacting list buffer, bound to the top level.
// Depends on clb_pkg and compacting_list_buffer_unit.
`timescale 1ns / 1ps

module clb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input clb_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input clb_pkg::out_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // One request at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  // Full status only with the store at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == clb_pkg::ST_FULL
      |-> out_data.fill_count == 9'(clb_pkg::CAPACITY))
    else $error("full status below capacity");

  // Refused requests return no data
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == clb_pkg::ST_RANGE || out_data.status == clb_pkg::ST_FULL)
      |-> out_data.read_value == 32'sd0)
    else $error("refused request returned data");

  // Fill count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill_count <= 9'(clb_pkg::CAPACITY))
    else $error("fill count beyond capacity");

endmodule

bind compacting_list_buffer_unit clb_checker u_clb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/tb.sv
// Testbench for compacting_list_buffer_unit: append, delete and read beats checked
// against a shadow copy of the list, with random idling on both channels.
// Depends on clb_pkg and the compacting_list_buffer_unit RTL.
`timescale 1ns / 1ps

module tb;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  clb_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  clb_pkg::out_t out_data;

  // Shadow of the list and the results still owed by the block
  logic signed [31:0] shadow_entries [clb_pkg::CAPACITY];
  int unsigned        shadow_count = 0;
  clb_pkg::out_t      pending_results [$];

  int unsigned mismatches = 0;
  bit          sender_idle_en = 1'b0;
  bit          receiver_idle_en = 1'b0;
  int unsigned hold_off_len = 0;

  compacting_list_buffer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it owes
  function automatic clb_pkg::out_t predict_result(input clb_pkg::in_t req);
    clb_pkg::out_t res;
    res.status = clb_pkg::ST_OK;
    res.read_value = '0;
    case (req.kind)
      clb_pkg::KIND_APPEND: begin
        if (shadow_count >= clb_pkg::CAPACITY) begin
          res.status = clb_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_count] = req.value;
          shadow_count++;
        end
      end
      clb_pkg::KIND_DELETE: begin
        if (req.position >= shadow_count) begin
          res.status = clb_pkg::ST_RANGE;
        end else begin
          for (int i = req.position; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      clb_pkg::KIND_READ: begin
        if (req.position >= shadow_count) res.status = clb_pkg::ST_RANGE;
        else res.read_value = shadow_entries[req.position];
      end
      default: ;
    endcase
    res.fill_count = 9'(shadow_count);
    return res;
  endfunction

  function automatic clb_pkg::in_t make_request(input logic [1:0] kind,
                                                input logic [31:0] value,
                                                input int unsigned position);
    clb_pkg::in_t req;
    req.kind = kind;
    req.value = value;
    req.position = 8'(position);
    return req;
  endfunction

  // Mostly in-range traffic; the list grows below high_water and shrinks above it
  function automatic clb_pkg::in_t random_request(input int unsigned high_water);
    clb_pkg::in_t req;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    req.value = $urandom;
    req.position = 8'($urandom);
    if (pick < 5) begin
      req.kind = clb_pkg::KIND_NOP;
    end else if (pick < 12) begin
      // out-of-range position while there is room above the count
      req.kind = pick[0] ? clb_pkg::KIND_READ : clb_pkg::KIND_DELETE;
      if (shadow_count < clb_pkg::CAPACITY)
        req.position = 8'($urandom_range(shadow_count, clb_pkg::CAPACITY - 1));
    end else if (pick < ((shadow_count < high_water) ? 55 : 25)) begin
      req.kind = clb_pkg::KIND_APPEND;
    end else begin
      req.kind = pick[1] ? clb_pkg::KIND_READ : clb_pkg::KIND_DELETE;
      if (shadow_count > 0) req.position = 8'($urandom_range(0, shadow_count - 1));
    end
    return req;
  endfunction

  // Offer one beat, with an optional idle burst first; return once it is taken
  task automatic send_request(input clb_pkg::in_t req);
    int unsigned gap;
    @(negedge clk);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_results.push_back(predict_result(req));
  endtask

  // Receiver stall: long hold-off on request, otherwise random bursts
  initial begin : result_stall_gen
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        for (int c = 1; c < n; c++) @(negedge clk);
      end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result beat against the oldest pending expectation
  always @(posedge clk) begin : result_check
    clb_pkg::out_t want;
    string         bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d value=%0d count=%0d", $realtime,
                   out_data.status, out_data.read_value, out_data.fill_count);
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (out_data.status !== want.status) bad = {bad, " status"};
        if (out_data.read_value !== want.read_value) bad = {bad, " read_value"};
        if (out_data.fill_count !== want.fill_count) bad = {bad, " fill_count"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch in%s: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, bad, want.status, want.read_value, want.fill_count,
                     out_data.status, out_data.read_value, out_data.fill_count);
        end
      end
    end
  end

  // Requests against an empty list
  task automatic test_empty_store();
    send_request(make_request(clb_pkg::KIND_NOP, 32'hDEAD_BEEF, 8'hA5));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 0));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'hFFFF_FFFF, 0));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 255));
  endtask

  // Value extremes, boundary positions and deletes at first, last and middle
  task automatic test_append_extremes();
    send_request(make_request(clb_pkg::KIND_APPEND, 32'h8000_0000, 255));
    send_request(make_request(clb_pkg::KIND_APPEND, 32'h7FFF_FFFF, 0));
    send_request(make_request(clb_pkg::KIND_APPEND, 32'h0000_0000, 128));
    send_request(make_request(clb_pkg::KIND_APPEND, 32'hFFFF_FFFF, 1));
    send_request(make_request(clb_pkg::KIND_APPEND, 32'h5555_AAAA, 127));
    send_request(make_request(clb_pkg::KIND_READ, 32'hFFFF_FFFF, 0));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 4));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 5));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 5));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 4));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 0));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 1));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 0));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 1));
    send_request(make_request(clb_pkg::KIND_NOP, 32'h1234_5678, 255));
  endtask

  // Fill to capacity, refuse appends and touch the top slot
  task automatic test_full_store();
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    while (shadow_count < clb_pkg::CAPACITY)
      send_request(make_request(clb_pkg::KIND_APPEND, $urandom, $urandom_range(0, 255)));
    send_request(make_request(clb_pkg::KIND_APPEND, $urandom, 0));
    send_request(make_request(clb_pkg::KIND_APPEND, $urandom, 255));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 255));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 0));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 255));
    send_request(make_request(clb_pkg::KIND_READ, 32'h0, 255));
    send_request(make_request(clb_pkg::KIND_APPEND, $urandom, 0));
    send_request(make_request(clb_pkg::KIND_DELETE, 32'h0, 0));
  endtask

  // Hold the result channel off so the block backs up into its input
  task automatic test_pressure();
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    hold_off_len = 120;
    repeat (16) send_request(random_request(32));
  endtask

  // Random phases with varying list depth; the second and the last run without idling
  task automatic test_random();
    int unsigned water [5];
    water = '{128, 224, 256, 160, 64};
    for (int p = 0; p < 5; p++) begin
      sender_idle_en = (p != 1) && (p != 4);
      receiver_idle_en = (p != 1) && (p != 4);
      repeat (50) send_request(random_request(water[p]));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_append_extremes();
    test_full_store();
    test_pressure();
    test_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // leave room for a full-length delete to show a stray result
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/clb_pkg.sv
hdl/clb_datapath.sv
hdl/clb_ctrl.sv
hdl/compacting_list_buffer_unit.sv
hdl/clb_checker.sv
dv/tb.sv
